@@ sv/fema_pkg.sv @@
package fema_pkg;

   // Sector numbers and extent lengths are 24 bits wide.
   localparam int SECTOR_W = 24;

   // Default capacity of the free-extent map.
   localparam int MAP_ENTRIES_DEF = 82;

   // Command codes carried on the request tuser bit.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes carried on the response tuser bits.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_MAP_FULL = 2'd2;

   // One entry of the map as it is stored in the extent memory.
   typedef struct packed {
      logic [SECTOR_W-1:0] start;
      logic [SECTOR_W-1:0] length;
   } extent_type;

endpackage

@@ sv/fema_ram.sv @@
module fema_ram #(
   parameter int DEPTH = fema_pkg::MAP_ENTRIES_DEF,
   parameter int AW    = 7
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output fema_pkg::extent_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  fema_pkg::extent_type wr_data
);

   fema_pkg::extent_type mem_ff [DEPTH];
   fema_pkg::extent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/free_extent_map_allocator.sv @@
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tuser: cmd; tdata: start, length
// rsp     | out       | rsp_tvalid/rsp_tready | tuser: status; tdata: alloc_start
//
// One request is worked on at a time; the next request can be accepted from
// the cycle in which the previous response becomes valid. The first-fit scan
// of an allocate, and the scan of a free for its merge or insert point, read
// one entry per cycle through the single read port of the extent memory and
// stop at the entry they need; the shift that opens or closes a gap then
// moves the remaining entries one per cycle.
// Reset clears the extent count and the handshake state; the memory itself
// holds no meaningful data until written. A stalled response waits in the
// output register while the next request is accepted and processed.
module free_extent_map_allocator #(
   parameter int MAP_ENTRIES = fema_pkg::MAP_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [23:0] start_sector, [47:24] length_sectors
   input  logic [0:0]  req_tuser,  // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [23:0] alloc_start
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   localparam int SW    = fema_pkg::SECTOR_W;
   localparam int AW    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAP_ENTRIES + 1);

   // The controller walks the map in a scan pass, for some requests followed by a
   // shift pass down or up, and then hands the result to the output register.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_SHDN = 5'b00100,
      S_SHUP = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [SW-1:0]        s_ff, s_in;
   logic [SW-1:0]        len_ff, len_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rptr_ff, rptr_in;
   logic [CNT_W-1:0]     dptr_ff, dptr_in;
   logic                 dv_ff, dv_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [1:0]           st_ff, st_in;
   logic [SW-1:0]        gr_ff, gr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [SW-1:0]        rsp_start_ff, rsp_start_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   fema_pkg::extent_type rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   fema_pkg::extent_type wr_data;

   logic                 accept;
   logic                 more_rd;
   logic                 more_up;
   logic [CNT_W-1:0]     rprev;
   logic [SW:0]          ext_end;

   fema_ram #(
      .DEPTH (MAP_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign more_rd    = (rptr_ff < cnt_ff);
   assign more_up    = (rptr_ff > pos_ff);
   assign rprev      = rptr_ff - 1'b1;
   // End of the entry being checked, kept one bit wider so it never wraps.
   assign ext_end    = {1'b0, rd_data.start} + {1'b0, rd_data.length};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      s_in          = s_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rptr_in       = rptr_ff;
      dptr_in       = dptr_ff;
      dv_in         = 1'b0;
      pos_in        = pos_ff;
      st_in         = st_ff;
      gr_in         = gr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rd_en         = 1'b0;
      rd_addr       = rptr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = dptr_ff[AW-1:0];
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser[0];
               s_in     = req_tdata[23:0];
               len_in   = req_tdata[47:24];
               gr_in    = '0;
               st_in    = fema_pkg::ST_OK;
               rptr_in  = '0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // Reads run one entry ahead of the check; a read issued in the
            // cycle of a hit is simply ignored.
            if (more_rd) begin
               rd_en   = 1'b1;
               dv_in   = 1'b1;
               dptr_in = rptr_ff;
               rptr_in = rptr_ff + 1'b1;
            end
            if (dv_ff) begin
               if (cmd_ff == fema_pkg::CMD_ALLOC) begin
                  if (rd_data.length >= len_ff) begin
                     gr_in = rd_data.start;
                     dv_in = 1'b0;
                     if (rd_data.length == len_ff) begin
                        // Exact fit: close the gap by moving later entries down.
                        rptr_in  = dptr_ff + 1'b1;
                        state_in = S_SHDN;
                     end else begin
                        wr_en          = 1'b1;
                        wr_data.start  = rd_data.start + len_ff;
                        wr_data.length = rd_data.length - len_ff;
                        state_in       = S_DONE;
                     end
                  end
               end else begin
                  if (ext_end == {1'b0, s_ff}) begin
                     // Freed extent follows this one directly: grow it.
                     wr_en          = 1'b1;
                     wr_data.length = rd_data.length + len_ff;
                     dv_in          = 1'b0;
                     state_in       = S_DONE;
                  end else if (rd_data.start > s_ff) begin
                     dv_in  = 1'b0;
                     pos_in = dptr_ff;
                     if (cnt_ff >= CNT_W'(MAP_ENTRIES)) begin
                        st_in    = fema_pkg::ST_MAP_FULL;
                        state_in = S_DONE;
                     end else begin
                        rptr_in  = cnt_ff;
                        state_in = S_SHUP;
                     end
                  end
               end
            end else if (!more_rd) begin
               // Whole map scanned without a decision.
               if (cmd_ff == fema_pkg::CMD_ALLOC) begin
                  st_in    = fema_pkg::ST_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  pos_in = cnt_ff;
                  if (cnt_ff >= CNT_W'(MAP_ENTRIES)) begin
                     st_in    = fema_pkg::ST_MAP_FULL;
                     state_in = S_DONE;
                  end else begin
                     rptr_in  = cnt_ff;
                     state_in = S_SHUP;
                  end
               end
            end
         end

         S_SHDN: begin
            // Entry j+1 is read while entry j-1 is written, so the two ports
            // never meet on one address.
            if (more_rd) begin
               rd_en   = 1'b1;
               dv_in   = 1'b1;
               dptr_in = rprev;
               rptr_in = rptr_ff + 1'b1;
            end
            if (dv_ff) begin
               wr_en = 1'b1;
            end else if (!more_rd) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_SHUP: begin
            // Move entries up from the top end, then drop the new extent
            // into the opened slot.
            if (more_up) begin
               rd_en   = 1'b1;
               rd_addr = rprev[AW-1:0];
               dv_in   = 1'b1;
               dptr_in = rptr_ff;
               rptr_in = rprev;
            end
            if (dv_ff) begin
               wr_en = 1'b1;
            end else if (!more_up) begin
               wr_en          = 1'b1;
               wr_addr        = pos_ff[AW-1:0];
               wr_data.start  = s_ff;
               wr_data.length = len_ff;
               cnt_in         = cnt_ff + 1'b1;
               state_in       = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_start_in  = gr_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      s_ff          <= s_in;
      len_ff        <= len_in;
      rptr_ff       <= rptr_in;
      dptr_ff       <= dptr_in;
      pos_ff        <= pos_in;
      st_ff         <= st_in;
      gr_ff         <= gr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_start_ff;

endmodule

@@ verif/free_extent_map_allocator_tb.sv @@
module free_extent_map_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_SIZE = fema_pkg::MAP_ENTRIES_DEF;

   // Number of random requests after the directed table and the fill sweep.
   localparam int RANDOM_REQUESTS = 1300;

   // The random part runs in segments that alternate between freeing and
   // allocating, so the map keeps swinging between empty and full.
   localparam int SEGMENT_LEN = 350;

   // The last stretch of the run has no idling on either side.
   localparam int STEADY_FROM = 1200;

   // The sender waits for the block to drain completely at this request.
   localparam int DRAIN_AT = 700;

   // The receiver holds off once for this many cycles after this many
   // responses, while the sender keeps offering requests.
   localparam int HOLD_AFTER  = 200;
   localparam int HOLD_CYCLES = 600;

   // One response, as the block reports it.
   typedef struct packed {
      logic [1:0]                    status;
      logic [fema_pkg::SECTOR_W-1:0] alloc_start;
   } grant_reply_type;

   // One row of the directed table. Where known is set, the expected
   // response is typed into the row; otherwise it comes from the map model.
   typedef struct packed {
      logic                          cmd;
      logic [fema_pkg::SECTOR_W-1:0] start;
      logic [fema_pkg::SECTOR_W-1:0] length;
      logic                          known;
      logic [1:0]                    status;
      logic [fema_pkg::SECTOR_W-1:0] alloc_start;
   } plan_row_type;

   // The directed sequence starts from an empty map. The comments give the
   // map contents after each row as (start, length) pairs.
   localparam int DIRECTED_ROWS = 18;
   localparam plan_row_type DIRECTED_PLAN [0:DIRECTED_ROWS-1] = '{
      // Allocations on an empty map find no space, whatever the count.
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000000, 1'b1, fema_pkg::ST_NO_SPACE, 24'h000000},
      '{fema_pkg::CMD_ALLOC, 24'hFFFFFF, 24'hFFFFFF, 1'b1, fema_pkg::ST_NO_SPACE, 24'h000000},
      // (100,10)
      '{fema_pkg::CMD_FREE,  24'h000100, 24'h000010, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // A zero-length extent goes in at the front: (0,0) (100,10)
      '{fema_pkg::CMD_FREE,  24'h000000, 24'h000000, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // A zero-length allocate takes the zero-length front entry away.
      '{fema_pkg::CMD_ALLOC, 24'h123456, 24'h000000, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // Freeing right behind an extent merges onto it: (100,30)
      '{fema_pkg::CMD_FREE,  24'h000110, 24'h000020, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // Nothing is large enough.
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000040, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // An exact fit removes the entry and empties the map.
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000030, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // Largest start and length: (FFFFFF,FFFFFF)
      '{fema_pkg::CMD_FREE,  24'hFFFFFF, 24'hFFFFFF, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // (0,FFFFFF) (FFFFFF,FFFFFF)
      '{fema_pkg::CMD_FREE,  24'h000000, 24'hFFFFFF, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // Largest count, exact fit on the front entry: (FFFFFF,FFFFFF)
      '{fema_pkg::CMD_ALLOC, 24'hABCDEF, 24'hFFFFFF, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // The end of the last extent only matches this start if the sum
      // wrapped, so it must be inserted instead: (FFFFFE,1) (FFFFFF,FFFFFF)
      '{fema_pkg::CMD_FREE,  24'hFFFFFE, 24'h000001, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // (FFFFFF,FFFFFF)
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000001, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // The shrunk start wraps past the top sector: (1,FFFFFD)
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000002, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // The merged length wraps: (1,2)
      '{fema_pkg::CMD_FREE,  24'hFFFFFE, 24'h000005, 1'b1, fema_pkg::ST_OK,       24'h000000},
      // A zero-length allocate grants the front start and leaves it alone.
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000000, 1'b0, fema_pkg::ST_OK,       24'h000000},
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000003, 1'b0, fema_pkg::ST_OK,       24'h000000},
      // Exact fit, the map is empty again.
      '{fema_pkg::CMD_ALLOC, 24'h000000, 24'h000002, 1'b0, fema_pkg::ST_OK,       24'h000000}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [47:0]         req_tdata;   // [23:0] start_sector, [47:24] length_sectors
   logic [0:0]          req_tuser;   // [0] cmd
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [23:0]         rsp_tdata;   // [23:0] alloc_start
   logic [1:0]          rsp_tuser;   // [1:0] status

   // Model of the free-extent map, kept in step with accepted requests.
   logic [fema_pkg::SECTOR_W-1:0] map_start  [0:MAP_SIZE-1];
   logic [fema_pkg::SECTOR_W-1:0] map_length [0:MAP_SIZE-1];
   int                            map_count;

   // Responses still owed by the block, oldest first.
   grant_reply_type     expected_grants [$];

   int                  error_count;
   int                  responses_seen;
   bit                  steady;

   free_extent_map_allocator #(
      .MAP_ENTRIES(MAP_SIZE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Applies one command to the map model and returns the response it owes.
   // Allocation is first fit from the lowest entry. A free merges onto the
   // first entry whose end (taken without wrap) equals the freed start, and
   // otherwise goes in ahead of the first entry that starts above it.
   function automatic grant_reply_type apply_map_command(
         input logic                          cmd,
         input logic [fema_pkg::SECTOR_W-1:0] s,
         input logic [fema_pkg::SECTOR_W-1:0] len);
      grant_reply_type reply;
      int              idx;
      int              pos;
      int              n;
      reply.status      = fema_pkg::ST_OK;
      reply.alloc_start = '0;
      if (cmd == fema_pkg::CMD_ALLOC) begin
         reply.status = fema_pkg::ST_NO_SPACE;
         for (idx = 0; idx < map_count; idx++) begin
            if (map_length[idx] >= len) begin
               reply.status      = fema_pkg::ST_OK;
               reply.alloc_start = map_start[idx];
               if (map_length[idx] == len) begin
                  for (pos = idx; pos + 1 < map_count; pos++) begin
                     map_start[pos]  = map_start[pos + 1];
                     map_length[pos] = map_length[pos + 1];
                  end
                  map_count--;
               end else begin
                  map_start[idx]  = map_start[idx] + len;
                  map_length[idx] = map_length[idx] - len;
               end
               break;
            end
         end
         return reply;
      end
      n   = map_count;
      pos = n;
      for (idx = 0; idx < n; idx++) begin
         if (({1'b0, map_start[idx]} + {1'b0, map_length[idx]}) == {1'b0, s}) begin
            map_length[idx] = map_length[idx] + len;
            return reply;
         end
         if (map_start[idx] > s) begin
            pos = idx;
            break;
         end
      end
      if (n >= MAP_SIZE) begin
         reply.status = fema_pkg::ST_MAP_FULL;
         return reply;
      end
      for (idx = n; idx > pos; idx--) begin
         map_start[idx]  = map_start[idx - 1];
         map_length[idx] = map_length[idx - 1];
      end
      map_start[pos]  = s;
      map_length[pos] = len;
      map_count       = n + 1;
      return reply;
   endfunction

   // Presents one request and waits for the edge that accepts it. At that
   // edge the model is advanced and the owed response is queued. Valid is
   // left high, so back-to-back requests need no second assignment.
   task automatic offer_request(input logic cmd,
                                input logic [fema_pkg::SECTOR_W-1:0] s,
                                input logic [fema_pkg::SECTOR_W-1:0] len,
                                input logic known,
                                input grant_reply_type typed);
      grant_reply_type modeled;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {len, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      modeled = apply_map_command(cmd, s, len);
      expected_grants.push_back(known ? typed : modeled);
   endtask

   // Drops valid for a burst of idle cycles, except in the steady stretch.
   task automatic maybe_rest_sender();
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Response checker: every accepted response is matched against the
   // oldest owed one, field by field.
   always @(posedge clock) begin : check_responses
      grant_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (expected_grants.size() == 0) begin
            $error("response with no request outstanding: status %0d alloc_start %h",
                   rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== want.alloc_start) begin
               $error("alloc_start: expected %h, got %h", want.alloc_start, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // Receiver: random bursts of back-pressure, one long hold-off that lets
   // the block fill up and stall its request side, and none at the end.
   initial begin : drive_response_ready
      bit held_off;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!steady && !held_off && responses_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Sender: directed table, a sweep that fills the map to capacity, then
   // the random part.
   initial begin : drive_requests
      grant_reply_type               typed;
      plan_row_type                  row;
      logic                          cmd;
      logic [fema_pkg::SECTOR_W-1:0] s;
      logic [fema_pkg::SECTOR_W-1:0] len;
      logic [31:0]                   rand_word;
      int                            k;
      int                            pick;
      int                            mode;
      int                            free_bias;
      int                            entry;

      error_count    = 0;
      responses_seen = 0;
      steady         = 1'b0;
      map_count      = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= fema_pkg::CMD_ALLOC;
      req_tdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++) begin
         row               = DIRECTED_PLAN[k];
         typed.status      = row.status;
         typed.alloc_start = row.alloc_start;
         offer_request(row.cmd, row.start, row.length, row.known, typed);
         maybe_rest_sender();
      end

      // Fill the map from the top down, so that every insert lands at the
      // front and shifts the whole map. The extents are spaced so that no
      // two of them merge.
      for (k = MAP_SIZE - 1; k >= 0; k--) begin
         offer_request(fema_pkg::CMD_FREE, 24'(24'h001000 + k * 24'h000100),
                       24'h000010, 1'b0, typed);
         maybe_rest_sender();
      end
      // A full map turns away a free that would need a new entry, both in
      // front of the first extent and past the last one.
      typed.status      = fema_pkg::ST_MAP_FULL;
      typed.alloc_start = '0;
      offer_request(fema_pkg::CMD_FREE, 24'h000800, 24'h000004, 1'b1, typed);
      offer_request(fema_pkg::CMD_FREE, 24'hFFFFFF, 24'h000001, 1'b1, typed);
      // A merge still goes through while the map is full.
      typed.status = fema_pkg::ST_OK;
      offer_request(fema_pkg::CMD_FREE, 24'h001010, 24'h000008, 1'b1, typed);
      offer_request(fema_pkg::CMD_ALLOC, 24'h000000, 24'h000018, 1'b0, typed);
      maybe_rest_sender();

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         steady    = (k >= STEADY_FROM);
         free_bias = ((k / SEGMENT_LEN) % 2 == 0) ? 75 : 30;
         pick      = int'($urandom_range(0, 99));
         mode      = int'($urandom_range(0, 3));
         rand_word = $urandom;
         s         = rand_word[fema_pkg::SECTOR_W-1:0];
         rand_word = $urandom;
         len       = rand_word[fema_pkg::SECTOR_W-1:0];
         if (pick < free_bias) begin
            cmd = fema_pkg::CMD_FREE;
            if (mode == 0 && map_count > 0) begin
               // Free right behind an existing extent, so that it merges.
               entry = int'($urandom_range(0, map_count - 1));
               s     = map_start[entry] + map_length[entry];
               len   = 24'($urandom_range(0, 63));
            end else if (mode != 3) begin
               // Small extents in a narrow window: mostly sorted inserts.
               s   = 24'($urandom_range(0, 24'h003FFF));
               len = 24'($urandom_range(0, 31));
            end
         end else begin
            cmd = fema_pkg::CMD_ALLOC;
            if (mode == 0) begin
               len = 24'($urandom_range(0, 40));
            end else if (mode == 1 && map_count > 0) begin
               // Length of some entry: an exact fit, unless an earlier entry is longer.
               entry = int'($urandom_range(0, map_count - 1));
               len   = map_length[entry];
            end else if (mode != 2) begin
               len = 24'($urandom_range(0, 255));
            end
         end
         if (k == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            while (expected_grants.size() != 0) @(posedge clock);
         end
         offer_request(cmd, s, len, 1'b0, typed);
         maybe_rest_sender();
      end
      req_tvalid <= 1'b0;

      // Wait for the owed responses, then a little longer than one worst
      // case command, so that a stray extra response would be seen.
      for (k = 0; k < 20000 && expected_grants.size() != 0; k++) @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $error("%0d responses never arrived", expected_grants.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("free_extent_map_allocator_tb: clean");
      end else begin
         $display("free_extent_map_allocator_tb: errors");
      end
      $finish;
   end

   // The time limit allows more than four times the slowest correct run: about
   // 1400 requests, each with scan and shift plus idling on both sides, and one
   // long hold-off.
   initial begin : run_limit
      #2_000_000;
      $display("free_extent_map_allocator_tb: errors");
      $finish;
   end

endmodule

@@ files.f @@
sv/fema_pkg.sv
sv/fema_ram.sv
sv/free_extent_map_allocator.sv
verif/free_extent_map_allocator_tb.sv
